[rtl/core/bfspe_pkg.sv]
// Shared types and constants for the shortest path engine.
`timescale 1ns / 1ps
`default_nettype none
package bfspe_pkg;

  localparam int DIST_W = 40;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CHECK = 2'd1,
    OP_ROW   = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_INIT  = 7'b0000010,
    ST_EREAD = 7'b0000100,
    ST_DREAD = 7'b0001000,
    ST_RELAX = 7'b0010000,
    ST_PASS  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

endpackage
`default_nettype wire

[rtl/core/bellman_ford_shortest_path_engine_unit.sv]
// Top level of the shortest path engine: edge memory, distance memory, relax sequencer.
// Load and clear act in the accepting cycle, no result. A query first initialises the distances
// of the n active vertices, then runs passes: a pass decision, then per edge a source distance
// read, dest read and relax/write; n passes for a check, at most n for a row query, 0 with no edges.
// A check strobes after its last pass; a row query then streams results one per cycle, never
// stalled. One query at a time, loads every cycle while idle. Reset: sync rst_n.
`timescale 1ns / 1ps
`default_nettype none
module bellman_ford_shortest_path_engine_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 4096,
  parameter int COST_BITS    = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire  [1:0]          in_opcode,
  input  wire  [5:0]          in_edge_from,
  input  wire  [5:0]          in_edge_to,
  input  wire  signed [31:0]  in_edge_cost,
  input  wire  [5:0]          in_source_vertex,
  output logic                out_valid,
  output logic [5:0]          out_destination,
  output logic signed [39:0]  out_distance,
  output logic                out_reachable,
  output logic                out_negative_cycle,
  output logic                out_last,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [1:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int DW = bfspe_pkg::DIST_W;
  localparam int ENTRY_W = 12 + COST_BITS;
  localparam logic signed [COST_BITS-1:0] CMAX = {1'b0, {(COST_BITS-1){1'b1}}};
  localparam logic signed [COST_BITS-1:0] CMIN = {1'b1, {(COST_BITS-1){1'b0}}};

  // configuration register
  logic [6:0] vcount_r;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 7'd1;
    end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
      vcount_r <= pwdata[6:0];
    end
  end
  always_comb begin
    prdata = 32'd0;
    if (paddr == 2'd0) prdata = {25'd0, vcount_r};
  end

  // effective vertex count
  logic [6:0] nv;
  always_comb begin
    if (vcount_r == 7'd0) nv = 7'd1;
    else if (vcount_r > 7'(MAX_VERTICES)) nv = 7'(MAX_VERTICES);
    else nv = vcount_r;
  end

  // saturate incoming cost
  logic signed [COST_BITS-1:0] cost_sat;
  always_comb begin
    if ($signed(in_edge_cost) > $signed(48'(signed'(CMAX)))) cost_sat = CMAX;
    else if ($signed(in_edge_cost) < $signed(48'(signed'(CMIN)))) cost_sat = CMIN;
    else cost_sat = COST_BITS'(in_edge_cost);
  end

  // memories
  logic [ENTRY_W-1:0] emem [MAX_EDGES];
  logic [ENTRY_W-1:0] erd_r;
  logic [DW:0]        dmem [MAX_VERTICES];
  logic [DW:0]        drd_r;
  logic [DW:0]        dsrc_r;

  logic [EW:0]   etotal_r;
  logic [EW-1:0] eidx_r;
  logic [6:0]    vidx_r;
  logic [6:0]    pass_r;
  logic          moved_r;
  logic          check_r;
  logic [5:0]    src_r;
  logic          dphase_r;
  bfspe_pkg::state_t state_r;

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_r != bfspe_pkg::ST_IDLE);

  // edge read address: fetch the next edge in the cycle before it is used
  logic [EW-1:0] eaddr;
  always_comb begin
    case (state_r)
      bfspe_pkg::ST_PASS:  eaddr = '0;
      bfspe_pkg::ST_RELAX: eaddr = eidx_r + 1'b1;
      default:             eaddr = eidx_r;
    endcase
  end

  // edge memory write and read
  logic            ewe;
  assign ewe = accept && (in_opcode == bfspe_pkg::OP_LOAD) && (etotal_r < (EW+1)'(MAX_EDGES));
  always_ff @(posedge clk) begin
    if (ewe) emem[etotal_r[EW-1:0]] <= {in_edge_from, in_edge_to, cost_sat};
    erd_r <= emem[eaddr];
  end

  logic [5:0] e_from, e_to;
  logic signed [COST_BITS-1:0] e_cost;
  assign e_from = erd_r[ENTRY_W-1 -: 6];
  assign e_to   = erd_r[ENTRY_W-7 -: 6];
  assign e_cost = erd_r[COST_BITS-1:0];

  // distance memory: one write port and one read port, read address muxed by state
  logic [VW-1:0] drd_addr;
  logic          dwe;
  logic [VW-1:0] dwaddr;
  logic [DW:0]   dwdata;
  always_ff @(posedge clk) begin
    if (dwe) dmem[dwaddr] <= dwdata;
    drd_r <= dmem[drd_addr];
  end

  // relax arithmetic
  logic signed [DW+1:0] sum;
  logic                 d_reach, s_reach, relax;
  logic signed [DW-1:0] sum_sat;
  assign s_reach = dsrc_r[DW];
  assign d_reach = drd_r[DW];
  assign sum = (DW+2)'($signed(dsrc_r[DW-1:0])) + (DW+2)'(e_cost);
  assign relax = s_reach && (!d_reach || (sum < (DW+2)'($signed(drd_r[DW-1:0]))));
  always_comb begin
    if (sum > (DW+2)'(bfspe_pkg::DIST_MAX)) sum_sat = bfspe_pkg::DIST_MAX;
    else if (sum < (DW+2)'(bfspe_pkg::DIST_MIN)) sum_sat = bfspe_pkg::DIST_MIN;
    else sum_sat = sum[DW-1:0];
  end

  logic e_ok;
  assign e_ok = ({1'b0, e_from} < nv) && ({1'b0, e_to} < nv);

  logic last_edge;
  assign last_edge = ({1'b0, eidx_r} == (etotal_r - 1'b1));

  always_comb begin
    drd_addr = VW'(vidx_r);
    dwe      = 1'b0;
    dwaddr   = VW'(vidx_r);
    dwdata   = '0;
    case (state_r)
      bfspe_pkg::ST_INIT: begin
        dwe    = 1'b1;
        dwdata = check_r ? {1'b1, {DW{1'b0}}}
                         : {(vidx_r[5:0] == src_r) && ({1'b0, src_r} < nv), {DW{1'b0}}};
      end
      bfspe_pkg::ST_EREAD: drd_addr = VW'(e_from);
      bfspe_pkg::ST_DREAD: drd_addr = VW'(e_to);
      bfspe_pkg::ST_RELAX: begin
        dwe    = e_ok && relax;
        dwaddr = VW'(e_to);
        dwdata = {1'b1, sum_sat};
      end
      default: drd_addr = VW'(vidx_r);
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bfspe_pkg::ST_IDLE;
      etotal_r  <= '0;
      out_valid <= 1'b0;
      eidx_r    <= '0;
      vidx_r    <= '0;
      pass_r    <= '0;
      moved_r   <= 1'b0;
      check_r   <= 1'b0;
      dphase_r  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        bfspe_pkg::ST_IDLE: begin
          if (accept) begin
            case (in_opcode)
              bfspe_pkg::OP_LOAD:  if (ewe) etotal_r <= etotal_r + 1'b1;
              bfspe_pkg::OP_CLEAR: etotal_r <= '0;
              default: begin
                check_r <= (in_opcode == bfspe_pkg::OP_CHECK);
                src_r   <= in_source_vertex;
                vidx_r  <= '0;
                pass_r  <= '0;
                moved_r <= 1'b0;
                state_r <= bfspe_pkg::ST_INIT;
              end
            endcase
          end
        end
        bfspe_pkg::ST_INIT: begin
          // set distance memory over the active vertices: all reachable at zero for a check, only the source for a row
          vidx_r <= vidx_r + 1'b1;
          if (vidx_r == nv - 1'b1) begin
            state_r <= bfspe_pkg::ST_PASS;
          end
        end
        bfspe_pkg::ST_PASS: begin
          // decide whether another pass runs
          if (pass_r != 7'd0 && (!moved_r && !check_r) || pass_r == nv
              || etotal_r == '0) begin
            vidx_r  <= '0;
            dphase_r <= 1'b0;
            if (check_r) begin
              out_valid          <= 1'b1;
              out_destination    <= '0;
              out_distance       <= '0;
              out_reachable      <= 1'b0;
              out_negative_cycle <= moved_r && (etotal_r != '0);
              out_last           <= 1'b1;
              state_r            <= bfspe_pkg::ST_IDLE;
            end else begin
              out_negative_cycle <= moved_r && (etotal_r != '0);
              state_r            <= bfspe_pkg::ST_EMIT;
            end
          end else begin
            pass_r  <= pass_r + 1'b1;
            moved_r <= 1'b0;
            eidx_r  <= '0;
            state_r <= bfspe_pkg::ST_EREAD;
          end
        end
        bfspe_pkg::ST_EREAD: state_r <= bfspe_pkg::ST_DREAD;
        bfspe_pkg::ST_DREAD: begin
          dsrc_r  <= drd_r;
          state_r <= bfspe_pkg::ST_RELAX;
        end
        bfspe_pkg::ST_RELAX: begin
          if (e_ok && relax) moved_r <= 1'b1;
          if (last_edge) begin
            state_r <= bfspe_pkg::ST_PASS;
          end else begin
            eidx_r  <= eidx_r + 1'b1;
            state_r <= bfspe_pkg::ST_EREAD;
          end
        end
        bfspe_pkg::ST_EMIT: begin
          // first cycle issues the read, then stream one vertex per cycle
          dphase_r <= 1'b1;
          if (dphase_r) begin
            out_valid       <= 1'b1;
            out_destination <= 6'(vidx_r - 1'b1);
            out_reachable   <= drd_r[DW];
            out_distance    <= drd_r[DW] ? drd_r[DW-1:0] : '0;
            out_last        <= (vidx_r == nv);
            if (vidx_r == nv) state_r <= bfspe_pkg::ST_IDLE;
          end
          if (vidx_r != nv) vidx_r <= vidx_r + 1'b1;
        end
        default: state_r <= bfspe_pkg::ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
